// ===== hdl/shake_cluster_constraint_assert.svh =====
// Assertion macros for the cluster constraint solver checker.
`ifndef SHAKE_CLUSTER_CONSTRAINT_ASSERT_SVH
`define SHAKE_CLUSTER_CONSTRAINT_ASSERT_SVH
`define SCC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== hdl/scc_pkg.sv =====
// Types and constants of the cluster constraint solver.
`default_nettype none
package scc_pkg;
   localparam int unsigned ACC_W = 64;
   localparam logic [1:0] CSR_MAX_ITER = 2'd0;
   localparam logic [1:0] CSR_TOLERANCE = 2'd1;
   localparam logic [1:0] CSR_VEL_MODE = 2'd2;
   localparam logic [7:0] RESET_MAX_ITER = 8'd15;
   localparam logic [31:0] RESET_TOLERANCE = 32'd42950;
   localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
   localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

   function automatic logic signed [31:0] sat32(input logic signed [ACC_W+1:0] x);
      logic signed [31:0] r;
      if (x > SAT_HI) r = 32'sh7fffffff;
      else if (x < SAT_LO) r = 32'sh80000000;
      else r = x[31:0];
      return r;
   endfunction
endpackage
`default_nettype wire

// ===== hdl/scc_if.sv =====
// Valid/ready channel interfaces of the cluster constraint solver.
`default_nettype none
interface scc_req_if;
   logic valid;
   logic ready;
   logic signed [31:0] ref_x, ref_y, ref_z, new_x, new_y, new_z;
   logic [31:0] inverse_mass;
   logic [31:0] constraint_distance;
   logic last_atom;
   modport source (output valid, ref_x, ref_y, ref_z, new_x, new_y, new_z, inverse_mass,
      constraint_distance, last_atom, input ready);
   modport sink (input valid, ref_x, ref_y, ref_z, new_x, new_y, new_z, inverse_mass,
      constraint_distance, last_atom, output ready);
endinterface

interface scc_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] out_x, out_y, out_z;
   logic out_last;
   logic converged;
   modport source (output valid, out_x, out_y, out_z, out_last, converged, input ready);
   modport sink (input valid, out_x, out_y, out_z, out_last, converged, output ready);
endinterface

interface scc_csr_if;
   logic valid;
   logic ready;
   logic [1:0] index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/shake_cluster_constraint.sv =====
// Top level of the cluster constraint solver.
// Atoms load one per cycle, central atom first; the item marked last starts the solve.
// A constraint that needs a correction runs the sequencing and the controller handshake
// plus at most two divisions of up to 88 quotient bits each in the shared restoring
// divider (fewer bits when a quotient saturates early); one that needs none runs only
// the first division. Sweeps repeat up to max_iterations times, then one result leaves
// per cycle that rsp ready is high. No atom is taken until the last result of the
// cluster has left.
`default_nettype none
module shake_cluster_constraint #(
   parameter int unsigned MAX_CLUSTER_ATOMS = 4
) (
   input wire logic clock,
   input wire logic reset,
   scc_req_if.sink req,
   scc_rsp_if.source rsp,
   scc_csr_if.sink csr
);
   import scc_pkg::*;
   localparam int unsigned IW = $clog2(MAX_CLUSTER_ATOMS+1);
   logic [7:0] max_iter_ff;
   logic [31:0] tol_ff;
   logic vel_ff;
   logic load, sw_start, sw_done, sw_ok;
   logic [IW-1:0] wr_idx, pair_idx, rd_idx;
   logic signed [31:0] in_ref [3], in_new [3], rd_val [3];

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff <= RESET_MAX_ITER;
         tol_ff <= RESET_TOLERANCE;
         vel_ff <= 1'b0;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_MAX_ITER: max_iter_ff <= csr.data[7:0];
            CSR_TOLERANCE: tol_ff <= csr.data;
            CSR_VEL_MODE: vel_ff <= csr.data[0];
            default: ;
         endcase
      end
   end

   assign in_ref[0] = req.ref_x;
   assign in_ref[1] = req.ref_y;
   assign in_ref[2] = req.ref_z;
   assign in_new[0] = req.new_x;
   assign in_new[1] = req.new_y;
   assign in_new[2] = req.new_z;

   scc_control #(.N(MAX_CLUSTER_ATOMS)) u_ctl (
      .clock, .reset, .req_fire(req.valid && req.ready), .req_last(req.last_atom),
      .rsp_ready(rsp.ready), .max_iter(max_iter_ff), .sw_done, .sw_ok,
      .req_ready(req.ready), .rsp_valid(rsp.valid), .rsp_last(rsp.out_last),
      .rsp_conv(rsp.converged), .load, .sw_start, .wr_idx, .pair_idx, .rd_idx);

   scc_datapath #(.N(MAX_CLUSTER_ATOMS)) u_dp (
      .clock, .reset, .load, .in_ref, .in_new, .in_mass(req.inverse_mass),
      .in_dist(req.constraint_distance), .wr_idx, .pair_idx, .rd_idx, .sw_start,
      .tolerance(tol_ff), .vel_mode(vel_ff), .sw_done, .sw_ok, .rd_val);

   assign rsp.out_x = rd_val[0];
   assign rsp.out_y = rd_val[1];
   assign rsp.out_z = rd_val[2];
endmodule
`default_nettype wire

// ===== hdl/scc_divider.sv =====
// Restoring divider, one quotient bit per cycle, floor(n*2^24/d) capped at 2^32.
`default_nettype none
module scc_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] num,
   input  wire logic [63:0] den,
   output logic             done,
   output logic [32:0]      quot
);
   import scc_pkg::*;
   localparam int unsigned NB = 88;
   logic [6:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic [87:0] sh_ff, sh_in;
   logic [64:0] rem_ff, rem_in;
   logic [33:0] q_ff, q_in;
   logic        cap_ff, cap_in;
   logic [63:0] den_ff, den_in;
   logic        done_ff, done_in;
   logic [64:0] trial;
   logic [33:0] qn;

   always_comb begin
      run_in = run_ff;
      cnt_in = cnt_ff;
      sh_in = sh_ff;
      rem_in = rem_ff;
      q_in = q_ff;
      cap_in = cap_ff;
      den_in = den_ff;
      done_in = 1'b0;
      trial = {rem_ff[63:0], sh_ff[87]};
      qn = {q_ff[32:0], 1'b0};
      if (start) begin
         run_in = (den != 64'd0);
         done_in = (den == 64'd0);
         cap_in = (den == 64'd0);
         cnt_in = 7'(NB - 1);
         sh_in = {num, 24'd0};
         rem_in = '0;
         q_in = '0;
         den_in = den;
      end else if (run_ff) begin
         sh_in = {sh_ff[86:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            qn[0] = 1'b1;
         end else begin
            rem_in = trial;
         end
         q_in = qn;
         if (qn > 34'h100000000) cap_in = 1'b1;
         if (cnt_ff == 7'd0 || cap_in) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
         cnt_in = cnt_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      sh_ff <= sh_in;
      rem_ff <= rem_in;
      q_ff <= q_in;
      cap_ff <= cap_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = cap_ff ? 33'h100000000 : q_ff[32:0];
endmodule
`default_nettype wire

// ===== hdl/scc_datapath.sv =====
// Datapath of the solver: atom stores, dot products, divisions and corrections.
`default_nettype none
module scc_datapath #(
   parameter int unsigned N = 4
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic load,
   input  wire logic signed [31:0] in_ref [3],
   input  wire logic signed [31:0] in_new [3],
   input  wire logic [31:0] in_mass,
   input  wire logic [31:0] in_dist,
   input  wire logic [$clog2(N+1)-1:0] wr_idx,
   input  wire logic [$clog2(N+1)-1:0] pair_idx,
   input  wire logic [$clog2(N+1)-1:0] rd_idx,
   input  wire logic sw_start,
   input  wire logic [31:0] tolerance,
   input  wire logic vel_mode,
   output logic sw_done,
   output logic sw_ok,
   output logic signed [31:0] rd_val [3]
);
   import scc_pkg::*;
   localparam int unsigned IW = $clog2(N+1);
   localparam int unsigned AW = $clog2(N);
   typedef enum logic [10:0] {
      D_IDLE = 11'b00000000001, D_DIFF = 11'b00000000010, D_PROD = 11'b00000000100,
      D_SUM = 11'b00000001000, D_AVG = 11'b00000010000, D_AVGW = 11'b00000100000,
      D_Q = 11'b00001000000, D_QW = 11'b00010000000, D_F = 11'b00100000000,
      D_K = 11'b01000000000, D_COR = 11'b10000000000
   } dst_type;
   dst_type st_ff, st_in;
   logic signed [31:0] ref_mem [N][3];
   logic signed [31:0] new_mem [N][3];
   logic [31:0] mass_mem [N];
   logic [31:0] bond_ff;
   logic signed [31:0] rij_ff [3];
   logic signed [31:0] rp_ff [3];
   logic signed [63:0] p1_ff [3], p2_ff [3], p3_ff [3];
   logic signed [63:0] rr_ff, rrp_ff, rpp_ff, d2_ff;
   logic [63:0] thr_ff;
   logic [31:0] avg_ff;
   logic signed [31:0] f_ff;
   logic signed [31:0] q_ff;
   logic signed [31:0] k0_ff, ki_ff;
   logic ok_ff, done_ff;
   logic [AW-1:0] wa, pa, ra;
   logic dv_start, dv_done;
   logic [63:0] dv_num, dv_den;
   logic [32:0] dv_q;
   logic neg_ff;
   logic signed [63:0] dd_num, dd_den;
   logic signed [63:0] err;
   logic [63:0] emag;
   logic [32:0] dmag;

   assign wa = wr_idx[AW-1:0];
   assign pa = pair_idx[AW-1:0];
   assign ra = rd_idx[AW-1:0];

   scc_divider u_div (.clock, .reset, .start(dv_start), .num(dv_num), .den(dv_den),
      .done(dv_done), .quot(dv_q));

   function automatic logic signed [63:0] fshr(input logic signed [63:0] x);
      return x >>> 24;
   endfunction

   function automatic logic signed [31:0] smul(input logic signed [31:0] s,
         input logic [31:0] u);
      logic [31:0] m;
      logic [63:0] p;
      logic signed [65:0] v;
      m = s[31] ? 32'(-s) : s;
      if (s == 32'sh80000000) m = 32'h80000000;
      p = ({32'd0, m} * {32'd0, u}) >> 24;
      v = s[31] ? -$signed({2'b0, p}) : $signed({2'b0, p});
      return sat32(v);
   endfunction

   always_comb begin
      err = d2_ff - rr_ff - (rrp_ff <<< 1) - rpp_ff;
      emag = err[63] ? 64'(-err) : 64'(err);
      dd_num = vel_mode ? rrp_ff : err;
      dd_den = vel_mode ? rr_ff : rrp_ff + rr_ff;
      dmag = f_ff[31] ? 33'(-$signed({f_ff[31], f_ff})) : {1'b0, f_ff};
      st_in = st_ff;
      dv_start = 1'b0;
      dv_num = 64'd0;
      dv_den = 64'd0;
      case (st_ff)
         D_IDLE: if (sw_start) st_in = D_DIFF;
         D_DIFF: st_in = D_PROD;
         D_PROD: st_in = D_SUM;
         D_SUM: st_in = D_AVG;
         D_AVG: begin
            dv_start = 1'b1;
            dv_num = 64'h800000;
            dv_den = {32'd0, mass_mem[0]} + {32'd0, mass_mem[pa]};
            st_in = D_AVGW;
         end
         D_AVGW: if (dv_done) st_in = D_Q;
         D_Q: begin
            if (vel_mode || emag >= thr_ff) begin
               dv_start = (dd_num != 0) && (dd_den != 0);
               dv_num = dd_num[63] ? 64'(-dd_num) : 64'(dd_num);
               dv_den = dd_den[63] ? 64'(-dd_den) : 64'(dd_den);
               st_in = dv_start ? D_QW : D_F;
            end else begin
               st_in = D_IDLE;
            end
         end
         D_QW: if (dv_done) st_in = D_F;
         D_F: st_in = D_K;
         D_K: st_in = D_COR;
         D_COR: st_in = D_IDLE;
         default: st_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= D_IDLE;
         bond_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         done_ff <= 1'b0;
         if (load && wr_idx == '0) bond_ff <= in_dist;
         if (st_ff == D_Q && !(vel_mode || emag >= thr_ff)) done_ff <= 1'b1;
         if (st_ff == D_COR) done_ff <= 1'b1;
      end
      if (load && wr_idx < IW'(N)) begin
         for (int c = 0; c < 3; c++) begin
            ref_mem[wa][c] <= in_ref[c];
            new_mem[wa][c] <= in_new[c];
         end
         mass_mem[wa] <= in_mass;
      end
      case (st_ff)
         D_DIFF: begin
            for (int c = 0; c < 3; c++) begin
               rij_ff[c] <= sat32(66'(ref_mem[0][c]) - 66'(ref_mem[pa][c]));
               rp_ff[c] <= sat32(66'(new_mem[0][c]) - 66'(new_mem[pa][c]) -
                  66'(sat32(66'(ref_mem[0][c]) - 66'(ref_mem[pa][c]))));
            end
            d2_ff <= $signed(({32'd0, bond_ff} * {32'd0, bond_ff}) >> 24);
         end
         D_PROD: begin
            for (int c = 0; c < 3; c++) begin
               p1_ff[c] <= fshr(64'(rij_ff[c]) * 64'(rij_ff[c]));
               p2_ff[c] <= fshr(64'(rij_ff[c]) * 64'(rp_ff[c]));
               p3_ff[c] <= fshr(64'(rp_ff[c]) * 64'(rp_ff[c]));
            end
            thr_ff <= (({24'd0, d2_ff[39:0]} * {48'd0, tolerance[31:16]}) +
               (({24'd0, d2_ff[39:0]} * {48'd0, tolerance[15:0]}) >> 16)) >> 16;
         end
         D_SUM: begin
            rr_ff <= p1_ff[0] + p1_ff[1] + p1_ff[2];
            rrp_ff <= p2_ff[0] + p2_ff[1] + p2_ff[2];
            rpp_ff <= p3_ff[0] + p3_ff[1] + p3_ff[2];
         end
         D_AVGW: if (dv_done) avg_ff <= dv_q[32] ? 32'hffffffff : dv_q[31:0];
         D_Q: begin
            neg_ff <= dd_num[63] != dd_den[63];
            if (dd_num == 0) q_ff <= '0;
            else if (dd_den == 0) q_ff <= dd_num[63] ? 32'sh80000000 : 32'sh7fffffff;
            ok_ff <= vel_mode || (emag < thr_ff);
         end
         D_QW: if (dv_done)
            q_ff <= sat32(neg_ff ? -$signed({33'd0, dv_q}) : $signed({33'd0, dv_q}));
         D_F: begin
            if (vel_mode) begin
               f_ff <= sat32(-66'sd2 * 66'(smul(q_ff, avg_ff)));
            end else begin
               f_ff <= smul(q_ff, avg_ff);
            end
         end
         D_K: begin
            k0_ff <= smul(f_ff, mass_mem[0]);
            ki_ff <= smul(f_ff, mass_mem[pa]);
         end
         D_COR: begin
            for (int c = 0; c < 3; c++) begin
               new_mem[0][c] <= sat32(66'(new_mem[0][c]) +
                  66'(fshr(64'(rij_ff[c]) * 64'(k0_ff))));
               new_mem[pa][c] <= sat32(66'(new_mem[pa][c]) -
                  66'(fshr(64'(rij_ff[c]) * 64'(ki_ff))));
            end
            if (vel_mode) ok_ff <= ({31'd0, dmag} << 8) <= {32'd0, tolerance};
         end
         default: ;
      endcase
   end

   assign sw_done = done_ff;
   assign sw_ok = ok_ff;
   always_comb begin
      for (int c = 0; c < 3; c++) rd_val[c] = new_mem[ra][c];
   end
endmodule
`default_nettype wire

// ===== hdl/scc_control.sv =====
// Controller of the solver: loading, sweep sequencing and result emission.
`default_nettype none
module scc_control #(
   parameter int unsigned N = 4
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_fire,
   input  wire logic req_last,
   input  wire logic rsp_ready,
   input  wire logic [7:0] max_iter,
   input  wire logic sw_done,
   input  wire logic sw_ok,
   output logic req_ready,
   output logic rsp_valid,
   output logic rsp_last,
   output logic rsp_conv,
   output logic load,
   output logic sw_start,
   output logic [$clog2(N+1)-1:0] wr_idx,
   output logic [$clog2(N+1)-1:0] pair_idx,
   output logic [$clog2(N+1)-1:0] rd_idx
);
   import scc_pkg::*;
   localparam int unsigned IW = $clog2(N+1);
   typedef enum logic [4:0] {
      C_LOAD = 5'b00001, C_ITER = 5'b00010, C_PAIR = 5'b00100,
      C_WAIT = 5'b01000, C_EMIT = 5'b10000
   } cst_type;
   cst_type st_ff;
   logic [IW-1:0] cnt_ff, n_ff, pi_ff, ri_ff;
   logic [7:0] it_ff;
   logic conv_ff, swok_ff;

   assign req_ready = st_ff == C_LOAD;
   assign load = req_fire;
   assign wr_idx = cnt_ff;
   assign pair_idx = pi_ff;
   assign rd_idx = ri_ff;
   assign rsp_valid = st_ff == C_EMIT;
   assign rsp_last = ri_ff == n_ff - IW'(1);
   assign rsp_conv = conv_ff;
   assign sw_start = st_ff == C_PAIR && pi_ff < n_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= C_LOAD;
         cnt_ff <= '0;
         conv_ff <= 1'b0;
      end else begin
         case (st_ff)
            C_LOAD: if (req_fire) begin
               if (cnt_ff < IW'(N)) cnt_ff <= cnt_ff + IW'(1);
               if (req_last) begin
                  n_ff <= (cnt_ff < IW'(N)) ? cnt_ff + IW'(1) : cnt_ff;
                  cnt_ff <= '0;
                  it_ff <= '0;
                  conv_ff <= 1'b0;
                  st_ff <= C_ITER;
               end
            end
            C_ITER: begin
               if (conv_ff || it_ff >= max_iter) begin
                  ri_ff <= '0;
                  st_ff <= C_EMIT;
               end else begin
                  it_ff <= it_ff + 8'd1;
                  swok_ff <= 1'b1;
                  pi_ff <= IW'(1);
                  st_ff <= C_PAIR;
               end
            end
            C_PAIR: begin
               if (pi_ff < n_ff) st_ff <= C_WAIT;
               else begin
                  conv_ff <= swok_ff;
                  st_ff <= C_ITER;
               end
            end
            C_WAIT: if (sw_done) begin
               if (!sw_ok) swok_ff <= 1'b0;
               pi_ff <= pi_ff + IW'(1);
               st_ff <= C_PAIR;
            end
            C_EMIT: if (rsp_ready) begin
               if (ri_ff == n_ff - IW'(1)) st_ff <= C_LOAD;
               ri_ff <= ri_ff + IW'(1);
            end
            default: st_ff <= C_LOAD;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== hdl/scc_checker.sv =====
// Port checker of the cluster constraint solver and its bind.
`default_nettype none
`include "shake_cluster_constraint_assert.svh"
module scc_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_last,
   input wire logic rsp_conv
);
   `SCC_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   `SCC_ASSERT_IMPL(a_load_quiet, clock, reset, req_valid && req_ready, !rsp_valid)
   `SCC_ASSERT_NEXT(a_last_frees, clock, reset, rsp_valid && rsp_ready && rsp_last, !rsp_valid)
   `SCC_ASSERT_NEXT(a_conv_hold, clock, reset, rsp_valid && rsp_ready && !rsp_last,
      rsp_conv == $past(rsp_conv))
endmodule

bind shake_cluster_constraint scc_checker u_chk (
   .clock, .reset, .req_valid(req.valid), .req_ready(req.ready), .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready), .rsp_last(rsp.out_last), .rsp_conv(rsp.converged));
`default_nettype wire
